FILE: design/qtprms_pkg.sv
// Shared types and constants for the quiet-tail pedestal/RMS block.
// No dependencies; used by quiet_tail_pedestal_rms_top and its testbench.
`default_nettype none
package qtprms_pkg;

    localparam int WINDOW_DEF  = 20;
    localparam int EXCLUDE_DEF = 2;

    localparam logic [15:0] SPREAD_LIMIT_RST = 16'hFFFF;

    typedef enum logic [1:0] {
        STATUS_QUIET = 2'd0,
        STATUS_SHORT = 2'd1,
        STATUS_NOISY = 2'd2
    } status_t;

    localparam logic REG_SPREAD_LIMIT = 1'b0;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WALK,
        ST_CHECK,
        ST_MUL,
        ST_SUB,
        ST_SQ_GO,
        ST_SQ_WAIT,
        ST_DR_GO,
        ST_DR_WAIT,
        ST_DP_GO,
        ST_DP_WAIT,
        ST_PUSH
    } state_t;

endpackage
`default_nettype wire

FILE: design/quiet_tail_pedestal_rms_top.sv
// Top level: sample ring memory, window walk, result sequencer and APB register.
// Depends on qtprms_pkg, qtprms_sqrt and qtprms_div.
`default_nettype none
// Channel   Ports                                     Direction
// s_        s_valid/s_ready, s_sample, s_last_sample  in: one ADC word per item
// m_        m_valid/m_ready, m_status, m_pedestal_x256, m_rms_x256
//                                                     out: one item per region end
// apb       psel/penable/pwrite/paddr/pwdata/prdata/pready  spread_limit at 0x0
//
// An ordinary sample is written into the ring memory and the next item is
// taken at once. A region end that is too short goes straight to the push
// state. A full region end walks WINDOW ring entries through a registered
// read and a squaring stage, then the product and difference states (CHECK,
// MUL, SUB), a root of the variance term, two reciprocal-multiply divisions
// and the push state; a noisy region goes from CHECK straight to the push
// state. A stalled m_ready holds the finished item in the output register;
// the next region end waits for it. Reset is synchronous, active low; the
// ring needs no clearing since only entries of the current region are read.
module quiet_tail_pedestal_rms_top #(
    parameter int WINDOW  = qtprms_pkg::WINDOW_DEF,
    parameter int EXCLUDE = qtprms_pkg::EXCLUDE_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [15:0] s_sample,
    input  wire logic        s_last_sample,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_status,
    output logic [23:0]      m_pedestal_x256,
    output logic [23:0]      m_rms_x256,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    localparam int DEPTH  = WINDOW + EXCLUDE;
    localparam int AW     = $clog2(DEPTH);
    localparam int NW     = $clog2(DEPTH + 1);
    localparam int IW     = $clog2(WINDOW + 1);
    localparam int CW     = $clog2(WINDOW);
    localparam int SUM_W  = 16 + CW;
    localparam int SQ_W   = 32 + CW;
    localparam int DW     = 32 + 2 * CW;
    localparam int RAD_W  = DW + 16;
    localparam int RH     = RAD_W / 2;
    localparam int DIV_N  = SUM_W + 9;

    // Register file
    logic [15:0] spread_limit_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == qtprms_pkg::REG_SPREAD_LIMIT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spread_limit_reg <= qtprms_pkg::SPREAD_LIMIT_RST;
        end else if (cfg_wr) begin
            spread_limit_reg <= pwdata[15:0];
        end
    end

    assign prdata = (paddr[2] == qtprms_pkg::REG_SPREAD_LIMIT) ? {16'h0000, spread_limit_reg}
                                                               : 32'h0000_0000;

    // Sample ring
    logic [15:0] ring_mem [DEPTH];
    logic [AW-1:0] wptr_reg, wptr_inc, rptr_reg;
    logic [NW-1:0] seen_reg, seen_inc;
    logic [15:0]   rd_data_reg;

    qtprms_pkg::state_t state_reg, state_next;

    logic accept, issue, win_done;
    logic [IW-1:0] issue_cnt_reg;
    logic          p1_reg, p2_reg;

    assign accept   = s_valid && s_ready;
    assign wptr_inc = (wptr_reg == AW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
    assign seen_inc = (seen_reg == NW'(DEPTH)) ? seen_reg : seen_reg + 1'b1;
    assign issue    = (state_reg == qtprms_pkg::ST_WALK) && (issue_cnt_reg != IW'(WINDOW));
    assign win_done = (issue_cnt_reg == IW'(WINDOW)) && !p1_reg && !p2_reg;

    always_ff @(posedge aclk) begin
        if (accept) begin
            ring_mem[wptr_reg] <= s_sample;
        end
        if (issue) begin
            rd_data_reg <= ring_mem[rptr_reg];
        end
    end

    // Accumulators and arithmetic
    logic [31:0]      sq_reg;
    logic [15:0]      val_reg, min_reg, max_reg, spread;
    logic [SUM_W-1:0] sum_reg;
    logic [SQ_W-1:0]  sumsq_reg;
    logic [DW-1:0]    prod_a_reg, prod_b_reg, d_reg;
    logic [1:0]       res_status_reg;
    logic [23:0]      res_ped_reg, res_rms_reg;
    logic             noisy;

    logic             sq_start, sq_busy;
    logic [RH-1:0]    root;
    logic             dv_start, dv_busy, dv_sel_ped;
    logic [DIV_N-1:0] dv_dividend, dv_quotient;

    assign spread = max_reg - min_reg;
    assign noisy  = spread > spread_limit_reg;

    qtprms_sqrt #(.RAD_W(RAD_W)) u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sq_start),
        .radicand ({d_reg, 16'h0000}),
        .busy     (sq_busy),
        .root     (root)
    );

    // Pedestal rounds half up: (256*sum + WINDOW/2) / WINDOW.
    assign dv_dividend = dv_sel_ped
        ? DIV_N'({sum_reg, 8'h00}) + DIV_N'(WINDOW / 2)
        : DIV_N'(root);

    qtprms_div #(.N_W(DIV_N), .DIVISOR(WINDOW)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (dv_start),
        .dividend (dv_dividend),
        .busy     (dv_busy),
        .quotient (dv_quotient)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            qtprms_pkg::ST_IDLE: begin
                if (accept && s_last_sample) begin
                    state_next = (seen_inc != NW'(DEPTH)) ? qtprms_pkg::ST_PUSH
                                                          : qtprms_pkg::ST_WALK;
                end
            end
            qtprms_pkg::ST_WALK:    if (win_done) state_next = qtprms_pkg::ST_CHECK;
            qtprms_pkg::ST_CHECK:   state_next = noisy ? qtprms_pkg::ST_PUSH : qtprms_pkg::ST_MUL;
            qtprms_pkg::ST_MUL:     state_next = qtprms_pkg::ST_SUB;
            qtprms_pkg::ST_SUB:     state_next = qtprms_pkg::ST_SQ_GO;
            qtprms_pkg::ST_SQ_GO:   state_next = qtprms_pkg::ST_SQ_WAIT;
            qtprms_pkg::ST_SQ_WAIT: if (!sq_busy) state_next = qtprms_pkg::ST_DR_GO;
            qtprms_pkg::ST_DR_GO:   state_next = qtprms_pkg::ST_DR_WAIT;
            qtprms_pkg::ST_DR_WAIT: if (!dv_busy) state_next = qtprms_pkg::ST_DP_GO;
            qtprms_pkg::ST_DP_GO:   state_next = qtprms_pkg::ST_DP_WAIT;
            qtprms_pkg::ST_DP_WAIT: if (!dv_busy) state_next = qtprms_pkg::ST_PUSH;
            qtprms_pkg::ST_PUSH:    if (!m_valid || m_ready) state_next = qtprms_pkg::ST_IDLE;
            default:                state_next = qtprms_pkg::ST_IDLE;
        endcase
    end

    // Control outputs
    always_comb begin
        s_ready    = 1'b0;
        sq_start   = 1'b0;
        dv_start   = 1'b0;
        dv_sel_ped = 1'b0;
        case (state_reg)
            qtprms_pkg::ST_IDLE:  s_ready = 1'b1;
            qtprms_pkg::ST_SQ_GO: sq_start = 1'b1;
            qtprms_pkg::ST_DR_GO: dv_start = 1'b1;
            qtprms_pkg::ST_DP_GO: begin
                dv_start   = 1'b1;
                dv_sel_ped = 1'b1;
            end
            default: ;
        endcase
    end

    // Control registers
    logic m_valid_reg;
    logic load_out;
    assign load_out = (state_reg == qtprms_pkg::ST_PUSH) && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= qtprms_pkg::ST_IDLE;
            wptr_reg      <= '0;
            seen_reg      <= '0;
            issue_cnt_reg <= '0;
            p1_reg        <= 1'b0;
            p2_reg        <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            p1_reg    <= issue;
            p2_reg    <= p1_reg;
            if (accept) begin
                wptr_reg      <= wptr_inc;
                seen_reg      <= s_last_sample ? '0 : seen_inc;
                issue_cnt_reg <= '0;
            end else if (issue) begin
                issue_cnt_reg <= issue_cnt_reg + 1'b1;
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers: walk from the oldest entry, square, accumulate
    always_ff @(posedge aclk) begin
        if (accept) begin
            rptr_reg       <= wptr_inc;
            sum_reg        <= '0;
            sumsq_reg      <= '0;
            min_reg        <= 16'hFFFF;
            max_reg        <= 16'h0000;
            res_status_reg <= qtprms_pkg::STATUS_SHORT;
            res_ped_reg    <= '0;
            res_rms_reg    <= '0;
        end
        if (issue) begin
            rptr_reg <= (rptr_reg == AW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (p1_reg) begin
            sq_reg  <= {16'h0000, rd_data_reg} * {16'h0000, rd_data_reg};
            val_reg <= rd_data_reg;
        end
        if (p2_reg) begin
            sum_reg   <= sum_reg + SUM_W'(val_reg);
            sumsq_reg <= sumsq_reg + SQ_W'(sq_reg);
            if (val_reg < min_reg) min_reg <= val_reg;
            if (val_reg > max_reg) max_reg <= val_reg;
        end
        if (state_reg == qtprms_pkg::ST_CHECK) begin
            res_status_reg <= noisy ? qtprms_pkg::STATUS_NOISY : qtprms_pkg::STATUS_QUIET;
            prod_a_reg     <= DW'(sumsq_reg) * DW'(WINDOW);
            prod_b_reg     <= DW'(sum_reg) * DW'(sum_reg);
        end
        if (state_reg == qtprms_pkg::ST_MUL) begin
            d_reg <= prod_a_reg - prod_b_reg;
        end
        if (state_reg == qtprms_pkg::ST_DR_WAIT && !dv_busy) begin
            res_rms_reg <= dv_quotient[23:0];
        end
        if (state_reg == qtprms_pkg::ST_DP_WAIT && !dv_busy) begin
            res_ped_reg <= dv_quotient[23:0];
        end
        if (load_out) begin
            m_status        <= res_status_reg;
            m_pedestal_x256 <= res_ped_reg;
            m_rms_x256      <= res_rms_reg;
        end
    end

    assign m_valid = m_valid_reg;
endmodule
`default_nettype wire

FILE: design/qtprms_sqrt.sv
// Iterative integer square root, two radicand bits per cycle.
// Depends on nothing but its parameter.
`default_nettype none
module qtprms_sqrt #(
    parameter int RAD_W = 60
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 start,
    input  wire logic [RAD_W-1:0]     radicand,
    output logic                      busy,
    output logic [RAD_W/2-1:0]        root
);
    localparam int RH = RAD_W / 2;
    localparam int CW = $clog2(RH + 1);

    logic [RAD_W-1:0] rad_reg;
    logic [RH+1:0]    rem_reg, rem_next;
    logic [RH-1:0]    root_reg, root_next;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg;
    logic [RH+3:0]    rem_sh, trial, diff;
    logic             ge;

    always_comb begin
        rem_sh    = {rem_reg, rad_reg[RAD_W-1 -: 2]};
        trial     = {2'b00, root_reg, 2'b01};
        ge        = rem_sh >= trial;
        diff      = rem_sh - trial;
        rem_next  = ge ? diff[RH+1:0] : rem_sh[RH+1:0];
        root_next = {root_reg[RH-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(RH);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign busy = busy_reg;
    assign root = root_reg;
endmodule
`default_nettype wire

FILE: design/qtprms_div.sv
// Division by a constant through a reciprocal multiply, split into two registered halves.
// Depends on nothing but its parameters.
`default_nettype none
module qtprms_div #(
    parameter int N_W     = 30,
    parameter int DIVISOR = 20
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           start,
    input  wire logic [N_W-1:0] dividend,
    output logic                busy,
    output logic [N_W-1:0]      quotient
);
    // floor(x * M / 2^SH) equals floor(x / DIVISOR) for every x below 2^N_W
    // when M = ceil(2^SH / DIVISOR) and SH = N_W + clog2(DIVISOR).
    localparam int SH = N_W + $clog2(DIVISOR);
    localparam int MW = N_W + 1;
    localparam int HW = MW - 16;
    localparam int LW = N_W + 16;
    localparam int UW = N_W + HW;
    localparam int PW = N_W + MW;
    localparam longint unsigned RECIP =
        ((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam logic [MW-1:0] RECIP_M  = MW'(RECIP);
    localparam logic [15:0]   RECIP_LO = RECIP_M[15:0];
    localparam logic [HW-1:0] RECIP_HI = RECIP_M[MW-1:16];

    logic [N_W-1:0] x_reg;
    logic [PW-1:0]  acc_reg;
    logic           lo_reg, hi_reg;
    logic [LW-1:0]  pp_lo;
    logic [UW-1:0]  pp_hi;

    assign pp_lo = LW'(x_reg) * LW'(RECIP_LO);
    assign pp_hi = UW'(x_reg) * UW'(RECIP_HI);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lo_reg <= 1'b0;
            hi_reg <= 1'b0;
        end else begin
            lo_reg <= start;
            hi_reg <= lo_reg;
        end
    end

    // Low half of the reciprocal first, then add the high half.
    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg <= dividend;
        end
        if (lo_reg) begin
            acc_reg <= PW'(pp_lo);
        end else if (hi_reg) begin
            acc_reg <= acc_reg + {pp_hi, 16'h0000};
        end
    end

    assign busy     = lo_reg | hi_reg;
    assign quotient = N_W'(acc_reg[PW-1:SH]);
endmodule
`default_nettype wire

FILE: dv/quiet_tail_pedestal_rms_top_test.sv
// Self-checking testbench for quiet_tail_pedestal_rms_top: streams ADC regions,
// predicts baseline mean/RMS/status per region end. Depends on qtprms_pkg.
module quiet_tail_pedestal_rms_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIN   = qtprms_pkg::WINDOW_DEF;
    localparam int EXCL  = qtprms_pkg::EXCLUDE_DEF;
    localparam int DEPTH = WIN + EXCL;
    localparam int IDLE_PCT    = 37;
    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_WAIT  = 300;
    localparam int HOLD_CYCLES = 1500;

    typedef struct {
        logic [15:0] sample;
        logic        last;
    } adc_word_t;

    typedef struct {
        qtprms_pkg::status_t status;
        logic [23:0]         ped;
        logic [23:0]         rms;
    } baseline_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [15:0] s_sample = '0;
    logic        s_last_sample = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic [23:0] m_pedestal_x256;
    logic [23:0] m_rms_x256;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    quiet_tail_pedestal_rms_top dut (.*);

    always #5 aclk = ~aclk;

    // Predictor state: sample history (index 0 oldest), samples seen in the region, limit.
    logic [15:0] hist [DEPTH];
    int unsigned seen_cnt;
    logic [15:0] spread_lim;

    adc_word_t pending_samples[$];
    baseline_t baseline_results[$];
    int  mismatches = 0;
    bit  no_idle = 1'b0;
    bit  hold_req = 1'b0;

    function automatic longint unsigned int_sqrt(longint unsigned y);
        longint unsigned root, bit_v;
        root  = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > y) bit_v >>= 2;
        while (bit_v != 0) begin
            if (y >= root + bit_v) begin
                y    = y - (root + bit_v);
                root = (root >> 1) + bit_v;
            end else begin
                root >>= 1;
            end
            bit_v >>= 2;
        end
        return root;
    endfunction

    // Shift one accepted sample in; queue the region result on a last sample.
    task automatic baseline_predict(logic [15:0] smp, logic last);
        baseline_t r;
        longint unsigned sum, sumsq, d;
        logic [15:0] lo, hi;
        for (int i = 0; i < DEPTH - 1; i++) hist[i] = hist[i + 1];
        hist[DEPTH - 1] = smp;
        if (seen_cnt < DEPTH) seen_cnt++;
        if (!last) return;
        r.status = qtprms_pkg::STATUS_QUIET;
        r.ped = '0;
        r.rms = '0;
        if (seen_cnt < DEPTH) begin
            r.status = qtprms_pkg::STATUS_SHORT;
        end else begin
            sum = 0;
            sumsq = 0;
            lo = hist[0];
            hi = hist[0];
            for (int i = 0; i < WIN; i++) begin
                if (hist[i] < lo) lo = hist[i];
                if (hist[i] > hi) hi = hist[i];
                sum   += hist[i];
                sumsq += longint'(hist[i]) * hist[i];
            end
            if (hi - lo > spread_lim) begin
                r.status = qtprms_pkg::STATUS_NOISY;
            end else begin
                d = WIN * sumsq - sum * sum;
                r.ped = 24'((sum * 512 + WIN) / (2 * WIN));
                r.rms = 24'(int_sqrt(d * 65536) / WIN);
            end
        end
        seen_cnt = 0;
        baseline_results.insert(baseline_results.size(), r);
    endtask

    // Sender: advance to the next pending item once the current one is taken.
    always @(posedge aclk) begin
        adc_word_t w;
        if (aresetn) begin
            if (s_valid && s_ready) baseline_predict(s_sample, s_last_sample);
            if (!s_valid || s_ready) begin
                if (pending_samples.size() > 0 &&
                    (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
                    w = pending_samples.pop_front();
                    s_valid       <= 1'b1;
                    s_sample      <= w.sample;
                    s_last_sample <= w.last;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random ready, plus one long hold-off so the block backs up.
    int unsigned hold_cnt = 0;
    bit hold_done = 1'b0;
    always @(posedge aclk) begin
        if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            hold_cnt  = HOLD_CYCLES;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Monitor: compare each result item with the oldest prediction.
    always @(posedge aclk) begin
        baseline_t e;
        if (aresetn && m_valid && m_ready) begin
            if (baseline_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result status=%0d ped=%0d rms=%0d",
                             m_status, m_pedestal_x256, m_rms_x256);
            end else begin
                e = baseline_results.pop_front();
                if (m_status !== e.status || m_pedestal_x256 !== e.ped ||
                    m_rms_x256 !== e.rms) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: exp status=%0d ped=%0d rms=%0d, got %0d %0d %0d",
                                 e.status, e.ped, e.rms, m_status,
                                 m_pedestal_x256, m_rms_x256);
                end
            end
        end
    end

    // Watchdog: end the run if nothing moves for too long.
    int unsigned quiet_cycles = 0;
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || psel) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic apb_write_limit(logic [15:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(4 * qtprms_pkg::REG_SPREAD_LIMIT);
        pwdata  <= {16'h0, value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        spread_lim = value;
    endtask

    // Wait until every queued item is taken and every result is back.
    task automatic drain();
        while (pending_samples.size() > 0 || s_valid || baseline_results.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic push_word(int unsigned v, bit last);
        adc_word_t w;
        w.sample = 16'(v);
        w.last   = last;
        pending_samples.insert(pending_samples.size(), w);
    endtask

    // Queue a region of len samples drawn from [base, base+spread], clipped.
    task automatic push_region(int len, int unsigned base, int unsigned spread);
        int unsigned v;
        for (int i = 0; i < len; i++) begin
            v = base + $urandom_range(spread);
            if (v > 65535) v = 65535;
            push_word(v, i == len - 1);
        end
    endtask

    // Random region mix: mostly full windows, some short, some long.
    task automatic random_regions(int n_items);
        int len, pick;
        int unsigned spr;
        while (n_items > 0) begin
            pick = $urandom_range(99);
            if (pick < 10)      len = $urandom_range(1, DEPTH - 1);
            else if (pick < 85) len = $urandom_range(DEPTH, DEPTH + 12);
            else                len = $urandom_range(DEPTH + 13, 70);
            case ($urandom_range(3))
                0: spr = 0;
                1: spr = $urandom_range(64);
                2: spr = $urandom_range(2000);
                default: spr = 65535;
            endcase
            push_region(len, $urandom_range(65535), spr);
            n_items -= len;
        end
    endtask

    initial begin
        for (int i = 0; i < DEPTH; i++) hist[i] = '0;
        seen_cnt   = 0;
        spread_lim = qtprms_pkg::SPREAD_LIMIT_RST;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: extremes, too short, exactly full, spread at the limit.
        push_region(DEPTH, 0, 0);
        push_region(DEPTH, 65535, 0);
        for (int i = 0; i < DEPTH; i++) push_word((i % 2) ? 65535 : 0, i == DEPTH - 1);
        push_word(16'h1234, 1'b1);
        push_region(DEPTH - 1, 300, 10);
        drain();
        apb_write_limit(16'd50);
        for (int i = 0; i < DEPTH; i++) push_word((i % 2) ? 150 : 100, i == DEPTH - 1);
        drain();
        apb_write_limit(16'd49);
        for (int i = 0; i < DEPTH; i++) push_word((i % 2) ? 150 : 100, i == DEPTH - 1);
        drain();
        apb_write_limit(16'd0);
        push_region(DEPTH, 777, 0);
        push_region(DEPTH + 3, 777, 1);
        drain();

        // Random phases over several limits; one runs with no idling, one
        // includes the long receiver hold-off.
        apb_write_limit(16'hFFFF);
        no_idle = 1'b1;
        random_regions(200);
        drain();
        no_idle = 1'b0;
        apb_write_limit(16'd0);
        random_regions(150);
        drain();
        apb_write_limit(16'd64);
        hold_req = 1'b1;
        random_regions(250);
        drain();
        apb_write_limit(16'($urandom_range(65535)));
        random_regions(200);
        drain();
        apb_write_limit(16'd2000);
        random_regions(200);
        drain();

        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
